// File: design/pfr_pkg.sv
// Shared constants, command and status codes for the packet fragment reassembler.
package pfr_pkg;

  localparam int MAX_PACKETS  = 2048;
  localparam int PACKET_BYTES = 1024;
  localparam int BUFFER_BYTES = 1048576;

  localparam int CMD_W    = 2;
  localparam int CNT_W    = 12;
  localparam int STRIDE_W = 11;
  localparam int IMG_W    = 21;
  localparam int IDX_W    = 16;
  localparam int LEN_W    = 11;
  localparam int POS_W    = 10;
  localparam int DATA_W   = 8;
  localparam int RADDR_W  = 20;
  localparam int STAT_W   = 3;

  localparam int FLAG_AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int BUF_AW  = $clog2(BUFFER_BYTES);
  localparam int PROD_W  = STRIDE_W + IDX_W;
  localparam int WADDR_W = IMG_W + 1;

  localparam logic [IMG_W-1:0] RECV_MAX = {IMG_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_FRAME = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STAT_W-1:0] ST_PAST_END = 3'd4;

endpackage

// File: design/pfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/packet_fragment_reassembler.sv
// Packet fragment reassembler: fill-flag RAM, frame store RAM and the sequencing control.
// Each accepted beat is registered, then reads the memories (state EXEC), then updates and
// registers its result (state FIN) once the output is free; no new beat is taken until then.
// A start command is followed by a sweep that clears all 2048 flag RAM entries; no beat
// is taken meanwhile. Reset (synchronous, active high) clears control state and runs
// the same sweep; the frame store is not cleared.
module packet_fragment_reassembler
  import pfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    command,
  input  logic [CNT_W-1:0]    packet_count,
  input  logic [STRIDE_W-1:0] packet_stride,
  input  logic [IMG_W-1:0]    image_bytes,
  input  logic [IDX_W-1:0]    packet_index,
  input  logic [LEN_W-1:0]    packet_length,
  input  logic [POS_W-1:0]    byte_position,
  input  logic [DATA_W-1:0]   data_byte,
  input  logic [RADDR_W-1:0]  read_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   status,
  output logic                frame_complete,
  output logic [DATA_W-1:0]   read_data,
  output logic [IMG_W-1:0]    bytes_received,
  output logic [CNT_W-1:0]    packets_missing
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]          state;
  logic [FLAG_AW-1:0]  clr_cnt;

  logic [CMD_W-1:0]    cmd_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [IMG_W-1:0]    img_q;
  logic [IDX_W-1:0]    idx_q;
  logic [LEN_W-1:0]    len_q;
  logic [POS_W-1:0]    pos_q;
  logic [DATA_W-1:0]   data_q;
  logic [RADDR_W-1:0]  raddr_q;
  logic [PROD_W-1:0]   prod;

  logic                frame_active;
  logic [CNT_W-1:0]    expected_packets;
  logic [STRIDE_W-1:0] stride_bytes;
  logic [IMG_W-1:0]    image_size;
  logic [IMG_W-1:0]    received_count;
  logic [CNT_W-1:0]    missing_count;
  logic                cur_accepted;
  logic [IMG_W-1:0]    cur_base;
  logic                cur_final;

  logic                frame_active_next;
  logic [CNT_W-1:0]    expected_packets_next;
  logic [STRIDE_W-1:0] stride_bytes_next;
  logic [IMG_W-1:0]    image_size_next;
  logic [IMG_W-1:0]    received_count_next;
  logic [CNT_W-1:0]    missing_count_next;
  logic                cur_accepted_next;
  logic [IMG_W-1:0]    cur_base_next;
  logic                cur_final_next;

  logic [STAT_W-1:0]   stat_c;
  logic                cmpl_c;
  logic [DATA_W-1:0]   rdat_c;
  logic                flag_set;
  logic                store_we;
  logic [WADDR_W-1:0]  store_waddr;
  logic                go_clear;

  logic                flag_rd;
  logic [DATA_W-1:0]   store_rd;
  logic                flag_we;
  logic [FLAG_AW-1:0]  flag_waddr;
  logic                flag_wdata;

  logic                accept;
  logic                out_free;
  logic                commit;
  logic [PROD_W:0]     end_sum;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_FIN) && out_free;
  assign end_sum  = {1'b0, prod} + (PROD_W+1)'(len_q);

  always_comb begin
    stat_c                = ST_OK;
    cmpl_c                = 1'b0;
    rdat_c                = '0;
    flag_set              = 1'b0;
    store_we              = 1'b0;
    store_waddr           = '0;
    go_clear              = 1'b0;
    frame_active_next     = frame_active;
    expected_packets_next = expected_packets;
    stride_bytes_next     = stride_bytes;
    image_size_next       = image_size;
    received_count_next   = received_count;
    missing_count_next    = missing_count;
    cur_accepted_next     = cur_accepted;
    cur_base_next         = cur_base;
    cur_final_next        = cur_final;
    unique case (cmd_q)
      CMD_START: begin
        go_clear              = 1'b1;
        frame_active_next     = 1'b1;
        expected_packets_next = (32'(cnt_q) > 32'(MAX_PACKETS)) ? CNT_W'(MAX_PACKETS) : cnt_q;
        stride_bytes_next     = (32'(stride_q) > 32'(PACKET_BYTES)) ?
                                STRIDE_W'(PACKET_BYTES) : stride_q;
        image_size_next       = (32'(img_q) > 32'(BUFFER_BYTES)) ? IMG_W'(BUFFER_BYTES) : img_q;
        received_count_next   = '0;
        missing_count_next    = expected_packets_next;
        cur_accepted_next     = 1'b0;
        cur_base_next         = '0;
        cur_final_next        = 1'b0;
      end
      CMD_DATA: begin
        if (!frame_active) begin
          stat_c = ST_NO_FRAME;
        end else begin
          if (pos_q == '0) begin
            cur_accepted_next = 1'b0;
            cur_final_next    = 1'b0;
            if (idx_q >= IDX_W'(expected_packets)) begin
              stat_c = ST_RANGE;
            end else if (flag_rd) begin
              stat_c = ST_DUP;
            end else begin
              flag_set = 1'b1;
              if (missing_count != '0) begin
                missing_count_next = missing_count - CNT_W'(1);
              end
              if (end_sum > (PROD_W+1)'(image_size)) begin
                stat_c = ST_PAST_END;
              end else begin
                cur_accepted_next = 1'b1;
                cur_base_next     = prod[IMG_W-1:0];
                cur_final_next    = ({1'b0, idx_q} + (IDX_W+1)'(1)) ==
                                    (IDX_W+1)'(expected_packets);
              end
            end
          end
          store_waddr = {1'b0, cur_base_next} + WADDR_W'(pos_q);
          if (cur_accepted_next && ({1'b0, pos_q} < len_q) &&
              (32'(store_waddr) < 32'(BUFFER_BYTES))) begin
            store_we = 1'b1;
            if (received_count != RECV_MAX) begin
              received_count_next = received_count + IMG_W'(1);
            end
            if (cur_final_next && (({1'b0, pos_q} + LEN_W'(1)) == len_q) &&
                (missing_count_next == '0) && (received_count_next >= image_size)) begin
              cmpl_c = 1'b1;
            end
          end
        end
      end
      CMD_READ: begin
        if (32'(raddr_q) < 32'(BUFFER_BYTES)) begin
          rdat_c = store_rd;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = idx_q[FLAG_AW-1:0];
    flag_wdata = 1'b1;
    if (state == S_CLEAR) begin
      flag_we    = 1'b1;
      flag_waddr = clr_cnt;
      flag_wdata = 1'b0;
    end else if (commit && flag_set) begin
      flag_we = 1'b1;
    end
  end

  pfr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_PACKETS)
  ) u_flags (
    .clk     (clk),
    .wr_en   (flag_we),
    .wr_addr (flag_waddr),
    .wr_data (flag_wdata),
    .rd_en   (state == S_EXEC),
    .rd_addr (idx_q[FLAG_AW-1:0]),
    .rd_data (flag_rd)
  );

  pfr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (commit && store_we),
    .wr_addr (store_waddr[BUF_AW-1:0]),
    .wr_data (data_q),
    .rd_en   ((state == S_EXEC) && (cmd_q == CMD_READ)),
    .rd_addr (raddr_q[BUF_AW-1:0]),
    .rd_data (store_rd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= command;
      cnt_q    <= packet_count;
      stride_q <= packet_stride;
      img_q    <= image_bytes;
      idx_q    <= packet_index;
      len_q    <= packet_length;
      pos_q    <= byte_position;
      data_q   <= data_byte;
      raddr_q  <= read_address;
    end
    if (state == S_EXEC) begin
      prod <= PROD_W'(stride_bytes) * PROD_W'(idx_q);
    end
    if (commit) begin
      status          <= stat_c;
      frame_complete  <= cmpl_c;
      read_data       <= rdat_c;
      bytes_received  <= received_count_next;
      packets_missing <= missing_count_next;
      stride_bytes    <= stride_bytes_next;
      image_size      <= image_size_next;
      cur_base        <= cur_base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_cnt          <= '0;
      out_valid        <= 1'b0;
      frame_active     <= 1'b0;
      expected_packets <= '0;
      received_count   <= '0;
      missing_count    <= '0;
      cur_accepted     <= 1'b0;
      cur_final        <= 1'b0;
    end else begin
      out_valid <= commit || (out_valid && out_stall);
      unique case (state)
        S_CLEAR: begin
          if (32'(clr_cnt) == 32'(MAX_PACKETS - 1)) begin
            clr_cnt <= '0;
            state   <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + FLAG_AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (commit) begin
            frame_active     <= frame_active_next;
            expected_packets <= expected_packets_next;
            received_count   <= received_count_next;
            missing_count    <= missing_count_next;
            cur_accepted     <= cur_accepted_next;
            cur_final        <= cur_final_next;
            state            <= go_clear ? S_CLEAR : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/pfr_check.sv
// Port-level assertions for the packet fragment reassembler and their bind.
module pfr_check
  import pfr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STAT_W-1:0]   status,
  input logic                frame_complete,
  input logic [DATA_W-1:0]   read_data,
  input logic [IMG_W-1:0]    bytes_received,
  input logic [CNT_W-1:0]    packets_missing
);

  a_reset_sweep: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(bytes_received))
    else $error("stalled result beat changed");

  a_complete_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_complete |-> status == ST_OK && packets_missing == '0)
    else $error("frame complete with error or missing packets");

  a_complete_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_complete |-> bytes_received != '0 && read_data == '0)
    else $error("frame complete without received bytes");

endmodule

bind packet_fragment_reassembler pfr_check u_pfr_check (.*);
